// ----- src/ietq_pkg.sv -----
// Shared types, constants and keymap table for the input event translator queue.
// No dependencies.
package ietq_pkg;

    localparam int KEYMAP_ENTRIES = 232;

    typedef enum logic [1:0] {
        FUNC_KEY   = 2'd0,
        FUNC_PTR   = 2'd1,
        FUNC_PULL  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_QUEUED   = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_IGNORED  = 3'd2,
        ST_RETURNED = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    localparam logic [15:0] EV_SYN = 16'd0;
    localparam logic [15:0] EV_KEY = 16'd1;
    localparam logic [15:0] EV_ABS = 16'd3;
    localparam logic [15:0] EV_REP = 16'd20;

    localparam logic [1:0] KP_PRESSED = 2'd0;
    localparam logic [1:0] KP_REPEAT  = 2'd3;

    localparam logic [2:0] PP_DOWN = 3'd2;
    localparam logic [2:0] PP_MOVE = 3'd3;
    localparam logic [2:0] PP_UP   = 3'd4;

    localparam logic [2:0] CFG_VIEW_W = 3'd0;
    localparam logic [2:0] CFG_VIEW_H = 3'd1;
    localparam logic [2:0] CFG_MAX_X  = 3'd2;
    localparam logic [2:0] CFG_MAX_Y  = 3'd3;
    localparam logic [2:0] CFG_TOUCH  = 3'd4;

    // Classified command from the front end to the back end.
    typedef struct packed {
        func_t       func;
        logic        ignore;
        logic [7:0]  keycode;
        logic [1:0]  key_phase;
        logic [2:0]  pointer_phase;
        logic [23:0] px;
        logic [23:0] py;
    } cmd_t;

    typedef struct packed {
        logic [15:0] ev_type;
        logic [15:0] ev_code;
        logic [15:0] ev_value;
    } event_t;

    function automatic logic [7:0] keymap(input logic [7:0] u);
        logic [7:0] k;
        k = 8'd0;
        case (u)
            8'd4: k = 8'd30;   8'd5: k = 8'd48;   8'd6: k = 8'd46;   8'd7: k = 8'd32;
            8'd8: k = 8'd18;   8'd9: k = 8'd33;   8'd10: k = 8'd34;  8'd11: k = 8'd35;
            8'd12: k = 8'd23;  8'd13: k = 8'd36;  8'd14: k = 8'd37;  8'd15: k = 8'd38;
            8'd16: k = 8'd50;  8'd17: k = 8'd49;  8'd18: k = 8'd24;  8'd19: k = 8'd25;
            8'd20: k = 8'd16;  8'd21: k = 8'd19;  8'd22: k = 8'd31;  8'd23: k = 8'd20;
            8'd24: k = 8'd22;  8'd25: k = 8'd47;  8'd26: k = 8'd17;  8'd27: k = 8'd45;
            8'd28: k = 8'd21;  8'd29: k = 8'd44;
            8'd30: k = 8'd2;   8'd31: k = 8'd3;   8'd32: k = 8'd4;   8'd33: k = 8'd5;
            8'd34: k = 8'd6;   8'd35: k = 8'd7;   8'd36: k = 8'd8;   8'd37: k = 8'd9;
            8'd38: k = 8'd10;  8'd39: k = 8'd11;
            8'd40: k = 8'd28;  8'd41: k = 8'd1;   8'd42: k = 8'd14;  8'd43: k = 8'd15;
            8'd44: k = 8'd57;  8'd45: k = 8'd12;  8'd46: k = 8'd13;  8'd47: k = 8'd26;
            8'd48: k = 8'd27;  8'd49: k = 8'd43;  8'd50: k = 8'd43;  8'd51: k = 8'd39;
            8'd52: k = 8'd40;  8'd53: k = 8'd41;  8'd54: k = 8'd51;  8'd55: k = 8'd52;
            8'd56: k = 8'd53;  8'd57: k = 8'd58;
            8'd58: k = 8'd59;  8'd59: k = 8'd60;  8'd60: k = 8'd61;  8'd61: k = 8'd62;
            8'd62: k = 8'd63;  8'd63: k = 8'd64;  8'd64: k = 8'd65;  8'd65: k = 8'd66;
            8'd66: k = 8'd67;  8'd67: k = 8'd68;  8'd68: k = 8'd87;  8'd69: k = 8'd88;
            8'd70: k = 8'd99;  8'd71: k = 8'd70;  8'd72: k = 8'd119; 8'd73: k = 8'd110;
            8'd74: k = 8'd102; 8'd75: k = 8'd104; 8'd76: k = 8'd111; 8'd77: k = 8'd107;
            8'd78: k = 8'd109; 8'd79: k = 8'd106; 8'd80: k = 8'd105; 8'd81: k = 8'd108;
            8'd82: k = 8'd103;
            8'd83: k = 8'd69;  8'd84: k = 8'd98;  8'd85: k = 8'd55;  8'd86: k = 8'd74;
            8'd87: k = 8'd78;  8'd88: k = 8'd96;  8'd89: k = 8'd79;  8'd90: k = 8'd80;
            8'd91: k = 8'd81;  8'd92: k = 8'd75;  8'd93: k = 8'd76;  8'd94: k = 8'd77;
            8'd95: k = 8'd71;  8'd96: k = 8'd72;  8'd97: k = 8'd73;  8'd98: k = 8'd82;
            8'd99: k = 8'd83;
            8'd100: k = 8'd86; 8'd101: k = 8'd127; 8'd102: k = 8'd116; 8'd103: k = 8'd117;
            8'd104: k = 8'd183; 8'd105: k = 8'd184; 8'd106: k = 8'd185; 8'd107: k = 8'd186;
            8'd108: k = 8'd187; 8'd109: k = 8'd188; 8'd110: k = 8'd189; 8'd111: k = 8'd190;
            8'd112: k = 8'd191; 8'd113: k = 8'd192; 8'd114: k = 8'd193; 8'd115: k = 8'd194;
            8'd116: k = 8'd134; 8'd117: k = 8'd138; 8'd118: k = 8'd130; 8'd119: k = 8'd132;
            8'd120: k = 8'd128; 8'd121: k = 8'd129; 8'd122: k = 8'd131; 8'd123: k = 8'd137;
            8'd124: k = 8'd133; 8'd125: k = 8'd135; 8'd126: k = 8'd136; 8'd127: k = 8'd113;
            8'd128: k = 8'd115; 8'd129: k = 8'd114;
            8'd224: k = 8'd29; 8'd225: k = 8'd42; 8'd226: k = 8'd56; 8'd227: k = 8'd125;
            8'd228: k = 8'd97; 8'd229: k = 8'd54; 8'd230: k = 8'd100; 8'd231: k = 8'd126;
            default: k = 8'd0;
        endcase
        return k;
    endfunction

endpackage

// ----- src/ietq_front.sv -----
// Front end: accepts input items, classifies them and maps HID usages.
// Depends on ietq_pkg.
module ietq_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [7:0]        key_usage,
    input  logic [1:0]        key_phase,
    input  logic [2:0]        pointer_phase,
    input  logic [23:0]       pointer_x,
    input  logic [23:0]       pointer_y,
    input  logic              view_on,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output ietq_pkg::cmd_t    cmd
);
    import ietq_pkg::*;

    logic  valid_reg;
    cmd_t  cmd_reg, cmd_next;

    assign in_ready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        cmd_next.func          = func_t'(func);
        cmd_next.keycode       = keymap(key_usage);
        cmd_next.key_phase     = key_phase;
        cmd_next.pointer_phase = pointer_phase;
        cmd_next.px            = pointer_x;
        cmd_next.py            = pointer_y;
        case (func_t'(func))
            FUNC_KEY:  cmd_next.ignore = (key_usage >= 8'(KEYMAP_ENTRIES));
            FUNC_PTR:  cmd_next.ignore = !view_on ||
                !(pointer_phase == PP_DOWN || pointer_phase == PP_MOVE ||
                  pointer_phase == PP_UP);
            FUNC_PULL: cmd_next.ignore = 1'b0;
            default:   cmd_next.ignore = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            cmd_reg <= cmd_next;
        end
    end
endmodule

// ----- src/ietq_scaler.sv -----
// Coordinate scaler: clamp, multiply, then restoring division, one quotient bit a cycle.
// Depends on nothing.
module ietq_scaler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [23:0] pos,
    input  logic [23:0] dim,
    input  logic [15:0] amax,
    output logic        busy,
    output logic [15:0] result
);
    // num = 2*p*amax + d  (< 2^42), den = 2*d (25 bits); quotient <= amax
    logic [41:0] num_reg;
    logic [24:0] den_reg;
    logic [25:0] rem_reg;
    logic [16:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic [1:0]  ph_reg;
    logic [23:0] p_reg;
    logic [15:0] amax_reg;
    logic [39:0] prod_reg;
    logic [25:0] rem_sh;

    assign busy   = (ph_reg != 2'd0);
    assign result = quo_reg[15:0];
    assign rem_sh = {rem_reg[24:0], num_reg[41]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= 2'd0;
        end else begin
            case (ph_reg)
                2'd0: if (start) begin
                    p_reg    <= (pos > dim) ? dim : pos;
                    den_reg  <= {dim, 1'b0};
                    amax_reg <= amax;
                    ph_reg   <= 2'd1;
                end
                2'd1: begin
                    prod_reg <= p_reg * amax_reg;
                    ph_reg   <= 2'd2;
                end
                2'd2: begin
                    num_reg <= {1'b0, prod_reg, 1'b0} + {18'd0, den_reg[24:1]};
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= 6'd42;
                    ph_reg  <= 2'd3;
                end
                default: begin
                    num_reg <= {num_reg[40:0], 1'b0};
                    if (rem_sh >= {1'b0, den_reg}) begin
                        rem_reg <= rem_sh - {1'b0, den_reg};
                        quo_reg <= {quo_reg[15:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[15:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) ph_reg <= 2'd0;
                end
            endcase
        end
    end
endmodule

// ----- src/ietq_back.sv -----
// Back end: builds event groups, writes and reads the ring, forms the result.
// Depends on ietq_pkg, ietq_scaler.
module ietq_back #(
    parameter int RING_DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  ietq_pkg::cmd_t    cmd,
    input  logic [23:0]       view_width,
    input  logic [23:0]       view_height,
    input  logic [15:0]       abs_max_x,
    input  logic [15:0]       abs_max_y,
    input  logic [15:0]       touch_button_code,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [2:0]        res_status,
    output ietq_pkg::event_t  res_event
);
    import ietq_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_SCALE_X, S_SCALE_Y, S_WRITE, S_READ, S_OUT
    } state_t;

    state_t          state_reg;
    logic [AW-1:0]   rd_reg, wr_reg;
    logic [47:0]     mem [RING_DEPTH];
    logic [47:0]     rd_data_reg;
    event_t          grp_reg [4];
    logic [2:0]      cnt_reg, idx_reg;
    logic [2:0]      status_reg;
    logic            ev_sel_reg;
    logic [15:0]     x_val_reg;
    cmd_t            c_reg;
    logic            sc_start;
    logic            sc_busy;
    logic [23:0]     sc_pos, sc_dim;
    logic [15:0]     sc_amax, sc_res;
    logic [AW-1:0]   free_cnt;

    assign free_cnt  = rd_reg - wr_reg - AW'(1);
    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res_status = status_reg;
    assign res_event = ev_sel_reg ? event_t'(rd_data_reg) : event_t'(48'd0);

    // X starts on command take-over, Y the cycle X finishes
    assign sc_start = (state_reg == S_IDLE && cmd_valid && cmd.func == FUNC_PTR &&
                       !cmd.ignore)
                   || (state_reg == S_SCALE_X && !sc_busy);
    assign sc_pos  = (state_reg == S_IDLE) ? cmd.px : c_reg.py;
    assign sc_dim  = (state_reg == S_IDLE) ? view_width : view_height;
    assign sc_amax = (state_reg == S_IDLE) ? abs_max_x : abs_max_y;

    ietq_scaler u_scaler (
        .aclk(aclk), .aresetn(aresetn), .start(sc_start),
        .pos(sc_pos), .dim(sc_dim), .amax(sc_amax),
        .busy(sc_busy), .result(sc_res)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == S_WRITE && idx_reg != cnt_reg) begin
            mem[wr_reg] <= grp_reg[idx_reg[1:0]];
        end
        if (state_reg == S_READ) begin
            rd_data_reg <= mem[rd_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rd_reg    <= '0;
            wr_reg    <= '0;
        end else begin
            case (state_reg)
                S_IDLE: if (cmd_valid) begin
                    c_reg      <= cmd;
                    ev_sel_reg <= 1'b0;
                    idx_reg    <= 3'd0;
                    if (cmd.ignore) begin
                        status_reg <= ST_IGNORED;
                        state_reg  <= S_OUT;
                    end else if (cmd.func == FUNC_PULL) begin
                        if (rd_reg == wr_reg) begin
                            status_reg <= ST_EMPTY;
                            state_reg  <= S_OUT;
                        end else begin
                            state_reg <= S_READ;
                        end
                    end else if (cmd.func == FUNC_KEY) begin
                        grp_reg[0] <= '{(cmd.key_phase == KP_REPEAT) ? EV_REP : EV_KEY,
                                        {8'd0, cmd.keycode},
                                        (cmd.key_phase == KP_PRESSED ||
                                         cmd.key_phase == KP_REPEAT) ? 16'd1 : 16'd0};
                        grp_reg[1] <= '{EV_SYN, 16'd0, 16'd0};
                        cnt_reg    <= 3'd2;
                        state_reg  <= S_WRITE;
                    end else begin
                        state_reg <= S_SCALE_X;
                    end
                end
                S_SCALE_X: if (!sc_busy) begin
                    x_val_reg <= sc_res;
                    state_reg <= S_SCALE_Y;
                end
                S_SCALE_Y: if (!sc_busy) begin
                    grp_reg[0] <= '{EV_ABS, 16'd0, x_val_reg};
                    grp_reg[1] <= '{EV_ABS, 16'd1, sc_res};
                    if (c_reg.pointer_phase == PP_MOVE) begin
                        grp_reg[2] <= '{EV_SYN, 16'd0, 16'd0};
                        cnt_reg    <= 3'd3;
                    end else begin
                        grp_reg[2] <= '{EV_KEY, touch_button_code,
                                        (c_reg.pointer_phase == PP_DOWN) ? 16'd1 : 16'd0};
                        grp_reg[3] <= '{EV_SYN, 16'd0, 16'd0};
                        cnt_reg    <= 3'd4;
                    end
                    state_reg <= S_WRITE;
                end
                S_WRITE: begin
                    if (idx_reg == 3'd0 && (AW + 3)'(cnt_reg) > (AW + 3)'(free_cnt)) begin
                        status_reg <= ST_DROPPED;
                        state_reg  <= S_OUT;
                    end else if (idx_reg == cnt_reg) begin
                        status_reg <= ST_QUEUED;
                        state_reg  <= S_OUT;
                    end else begin
                        wr_reg  <= wr_reg + AW'(1);
                        idx_reg <= idx_reg + 3'd1;
                    end
                end
                S_READ: begin
                    rd_reg     <= rd_reg + AW'(1);
                    status_reg <= ST_RETURNED;
                    ev_sel_reg <= 1'b1;
                    state_reg  <= S_OUT;
                end
                S_OUT: if (res_ready) begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Y starts the cycle X finishes: the scaler must be idle then.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCALE_Y && !sc_busy) |-> $past(state_reg) == S_SCALE_Y ||
            $past(state_reg) == S_SCALE_X)
        else $error("scale sequence broken");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && status_reg == ST_DROPPED) |-> $stable(wr_reg))
        else $error("dropped group touched ring");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && status_reg == ST_RETURNED) |-> ev_sel_reg)
        else $error("returned event not selected");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE && idx_reg != 3'd0) |-> wr_reg != rd_reg)
        else $error("ring overrun");
endmodule

// ----- src/input_event_translator_queue.sv -----
// Top level: configuration registers, front classifier, back ring engine.
// Depends on ietq_pkg, ietq_front, ietq_back.
//
//  channel  | direction | contents
//  s_axis   | in        | tdata: func, key_usage, key_phase, pointer_phase, pointer_x, pointer_y
//  m_axis   | out       | tdata: status, event_type, event_code, event_value
//  cfg      | in        | cfg_index selects register, cfg_data value
//
// For a pointer item the back end uses the shared scaler twice, once per axis,
// dividing one quotient bit a cycle.
// Reset is synchronous on aresetn; the ring is empty after reset.
// A stalled result holds the back end; the front register holds one further
// item meanwhile.
module input_event_translator_queue #(
    parameter int RING_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // func, key_usage, key_phase, pointer_phase, x, y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // status, event_type, event_code, event_value
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import ietq_pkg::*;

    logic [23:0] view_w_reg, view_h_reg;
    logic [15:0] max_x_reg, max_y_reg, touch_reg;
    logic        cmd_valid, cmd_ready;
    cmd_t        cmd;
    event_t      ev;
    logic [2:0]  st;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_w_reg <= '0;
            view_h_reg <= '0;
            max_x_reg  <= 16'd32767;
            max_y_reg  <= 16'd32767;
            touch_reg  <= 16'd330;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_VIEW_W: view_w_reg <= cfg_data;
                CFG_VIEW_H: view_h_reg <= cfg_data;
                CFG_MAX_X:  max_x_reg  <= cfg_data[15:0];
                CFG_MAX_Y:  max_y_reg  <= cfg_data[15:0];
                CFG_TOUCH:  touch_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    ietq_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .func(s_axis_tdata[1:0]), .key_usage(s_axis_tdata[9:2]),
        .key_phase(s_axis_tdata[11:10]), .pointer_phase(s_axis_tdata[14:12]),
        .pointer_x(s_axis_tdata[38:15]), .pointer_y(s_axis_tdata[62:39]),
        .view_on(view_w_reg != 24'd0 && view_h_reg != 24'd0),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    ietq_back #(.RING_DEPTH(RING_DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .view_width(view_w_reg), .view_height(view_h_reg),
        .abs_max_x(max_x_reg), .abs_max_y(max_y_reg), .touch_button_code(touch_reg),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .res_status(st), .res_event(ev)
    );

    assign m_axis_tdata = {5'd0, ev.ev_value, ev.ev_code, ev.ev_type, st};
endmodule
